/* design/mts_pkg.sv */
// Shared types, widths and helpers for the midpoint triangle subdivider.
// Used by midpoint_triangle_subdivider; depends on nothing else.
package mts_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int CORNER_W     = 6;
    localparam int SLOT_W       = 6;
    localparam int BASE_W       = 7;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int NV_CAP_W     = $clog2(MAX_VERTICES + 1);
    localparam int NV_W         = (NV_CAP_W > BASE_W) ? NV_CAP_W : BASE_W;
    localparam int TABLE_SIZE   = MAX_VERTICES * MAX_VERTICES;
    localparam int ADDR_W       = $clog2(TABLE_SIZE);
    localparam int EPOCH_W      = 8;
    localparam int WORD_W       = EPOCH_W + IDX_W;
    localparam int S_TDATA_W    = 24;
    localparam int M_TDATA_W    = 24;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    localparam logic KIND_MIDPOINT = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    // Output slot codes: 0..2 midpoint commands, then the four triangles
    localparam logic [2:0] SLOT_MID_AB = 3'd0;
    localparam logic [2:0] SLOT_MID_BC = 3'd1;
    localparam logic [2:0] SLOT_MID_CA = 3'd2;
    localparam logic [2:0] SLOT_TRI_A  = 3'd3;
    localparam logic [2:0] SLOT_TRI_B  = 3'd4;
    localparam logic [2:0] SLOT_TRI_C  = 3'd5;
    localparam logic [2:0] SLOT_TRI_M  = 3'd6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EDGE0,
        ST_EDGE1,
        ST_EDGE2
    } mts_state_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [IDX_W-1:0]   idx;
    } mts_word_t;

    // Everything one triangle produces, gathered before it is streamed out
    typedef struct packed {
        logic [2:0]             mid_valid;
        logic [2:0]             mid_ovf;
        logic [2:0][SLOT_W-1:0] mid_lo;
        logic [2:0][SLOT_W-1:0] mid_hi;
        logic [2:0][SLOT_W-1:0] mid_idx;
        logic [SLOT_W-1:0]      crn_a;
        logic [SLOT_W-1:0]      crn_b;
        logic [SLOT_W-1:0]      crn_c;
        logic [SLOT_W-1:0]      m_ab;
        logic [SLOT_W-1:0]      m_bc;
        logic [SLOT_W-1:0]      m_ca;
        logic                   ovf;
    } mts_rec_t;

    function automatic logic in_table(input logic [CORNER_W-1:0] hi);
        return int'(hi) < MAX_VERTICES;
    endfunction

    function automatic logic [ADDR_W-1:0] pair_addr(input logic [CORNER_W-1:0] lo,
                                                    input logic [CORNER_W-1:0] hi);
        return ADDR_W'(ADDR_W'(lo) * ADDR_W'(MAX_VERTICES) + ADDR_W'(hi));
    endfunction

    // First present midpoint slot at or after 'from', else the first triangle
    function automatic logic [2:0] first_slot(input logic [2:0] mv, input logic [2:0] from);
        logic [2:0] res;
        res = SLOT_TRI_A;
        for (int i = 2; i >= 0; i--) begin
            if ((3'(i) >= from) && mv[i]) begin
                res = 3'(i);
            end
        end
        return res;
    endfunction

endpackage

/* design/mts_ram.sv */
// Generic single-write, single-read RAM with registered read data; depends on nothing.
// Read during write to the same address returns the old contents.
module mts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* design/midpoint_triangle_subdivider.sv */
// Midpoint triangle subdivider: splits each triangle beat into four, issuing new-midpoint
// commands for edges not yet in the edge table. Depends on mts_pkg and mts_ram.
// An accepted beat passes the read and edge states, then the hand-off and output registers.
// Throughput: the edge engine handles each triangle as one table read, then three
// read-modify-write steps on the edge table; the output sends 4 to 7 beats per
// triangle, one a cycle while m_tready is high.
// Reset: synchronous, active low; a clearing pass over all 4096 table entries follows with s_tready
// low, and the same pass runs again on every 255th first-triangle beat (epoch wrap).
module midpoint_triangle_subdivider (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: base_vertex_count
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mts_pkg::BASE_W-1:0]     cfg_data,
    // input triangles
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [mts_pkg::S_TDATA_W-1:0]  s_tdata,   // corner_a, corner_b, corner_c, zero pad
    input  logic                           s_tuser,   // first_triangle
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mts_pkg::M_TDATA_W-1:0]  m_tdata,   // slot_one, slot_two, slot_three,
                                                      // overflow, zero pad
    output logic                           m_tuser,   // result_kind
    output logic                           m_tlast    // last_of_run
);

    import mts_pkg::*;

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    mts_state_t             state_reg, state_next;
    logic [ADDR_W-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [EPOCH_W-1:0]     epoch_reg, epoch_next;
    logic [NV_W-1:0]        nv_reg, nv_next;
    logic                   ovf_reg, ovf_next;
    logic [BASE_W-1:0]      base_reg;

    // set by every accepted triangle, cleared when a clearing pass ends; marks a held triangle in a wrap clear
    logic                   busy_item_reg, busy_item_next;

    // accepted triangle, held through the edge steps
    logic [CORNER_W-1:0]    a_reg, b_reg, c_reg;

    // per-triangle record being built, then handed to the output side
    mts_rec_t               rec_reg, rec_next;
    mts_rec_t               hand_reg;
    logic                   hand_valid_reg, hand_valid_next;

    // output side
    mts_rec_t               emit_reg;
    logic                   emit_valid_reg, emit_valid_next;
    logic [2:0]             slot_reg, slot_next;

    // table port and one-deep write forwarding
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    mts_word_t              wr_word;
    logic [ADDR_W-1:0]      rd_addr;
    logic [WORD_W-1:0]      rd_data;
    logic [ADDR_W-1:0]      rd_addr_reg;
    logic                   fwd_valid_reg;
    logic [ADDR_W-1:0]      fwd_addr_reg;
    mts_word_t              fwd_word_reg;

    // handshake helpers
    logic                   s_fire;
    logic                   m_fire;
    logic                   emit_done;
    logic                   emit_load;
    logic                   hand_free;
    logic                   clr_done;
    logic                   in_first;
    logic [CORNER_W-1:0]    in_a, in_b, in_c;

    // edge resolution
    logic [CORNER_W-1:0]    rd_p, rd_q, rd_lo, rd_hi;
    logic [CORNER_W-1:0]    cur_p, cur_q, cur_lo, cur_hi;
    logic                   cur_tab;
    logic [ADDR_W-1:0]      cur_addr;
    mts_word_t              cur_word;
    logic                   cur_hit;
    logic                   cur_sat;
    logic [IDX_W-1:0]       take_idx;
    logic [IDX_W-1:0]       mid_idx;
    logic                   ovf_after;
    logic                   resolving;
    mts_rec_t               rec_upd;

    assign cfg_ready = 1'b1;
    assign in_a      = s_tdata[CORNER_W-1:0];
    assign in_b      = s_tdata[2*CORNER_W-1:CORNER_W];
    assign in_c      = s_tdata[3*CORNER_W-1:2*CORNER_W];
    assign in_first  = s_tuser;

    // Take a new triangle while idle or while the previous one finishes its last step
    assign s_tready  = (state_reg == ST_IDLE) || (state_reg == ST_EDGE2);
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;
    assign emit_done = m_fire && (slot_reg == SLOT_TRI_M);
    assign emit_load = hand_valid_reg && (!emit_valid_reg || emit_done);
    // Nothing but the engine fills the hand-off register, so a free slot seen
    // before the first edge step is still free at the last one.
    assign hand_free = !hand_valid_reg || emit_load;
    assign clr_done  = (clr_cnt_reg == ADDR_W'(TABLE_SIZE - 1));

    // ------------------------------------------------------------------
    // Edge table
    // ------------------------------------------------------------------
    mts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_SIZE)
    ) u_edge_ram (
        .clk     (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_done) begin
                    // a held triangle waits in the read state after a wrap clear
                    state_next = busy_item_reg ? ST_READ : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (in_first && (epoch_reg == EPOCH_LAST)) ? ST_CLEAR : ST_READ;
                end
            end
            ST_READ: begin
                if (hand_free) begin
                    state_next = ST_EDGE0;
                end
            end
            ST_EDGE0: state_next = ST_EDGE1;
            ST_EDGE1: state_next = ST_EDGE2;
            ST_EDGE2: begin
                if (s_fire) begin
                    state_next = (in_first && (epoch_reg == EPOCH_LAST)) ? ST_CLEAR : ST_READ;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        busy_item_next = busy_item_reg;
        if (s_fire) begin
            busy_item_next = 1'b1;
        end else if ((state_reg == ST_CLEAR) && clr_done) begin
            busy_item_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Edge selection: read one edge ahead, resolve the current one
    // ------------------------------------------------------------------
    always_comb begin
        case (state_reg)
            ST_EDGE0: begin
                rd_p = b_reg;
                rd_q = c_reg;
            end
            ST_EDGE1: begin
                rd_p = c_reg;
                rd_q = a_reg;
            end
            default: begin
                rd_p = a_reg;
                rd_q = b_reg;
            end
        endcase
        case (state_reg)
            ST_EDGE1: begin
                cur_p = b_reg;
                cur_q = c_reg;
            end
            ST_EDGE2: begin
                cur_p = c_reg;
                cur_q = a_reg;
            end
            default: begin
                cur_p = a_reg;
                cur_q = b_reg;
            end
        endcase
    end

    assign rd_lo    = (rd_p < rd_q) ? rd_p : rd_q;
    assign rd_hi    = (rd_p < rd_q) ? rd_q : rd_p;
    assign cur_lo   = (cur_p < cur_q) ? cur_p : cur_q;
    assign cur_hi   = (cur_p < cur_q) ? cur_q : cur_p;
    assign cur_tab  = in_table(cur_hi);
    assign cur_addr = pair_addr(cur_lo, cur_hi);

    // Forward the write made in the cycle the read went out
    assign cur_word = (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg)) ?
                      fwd_word_reg : mts_word_t'(rd_data);
    assign cur_hit  = cur_tab && (cur_word.epoch == epoch_reg);

    // Next free index, saturating at the top of the vertex range
    assign cur_sat  = (nv_reg >= NV_W'(MAX_VERTICES));
    assign take_idx = cur_sat ? IDX_W'(MAX_VERTICES - 1) : nv_reg[IDX_W-1:0];
    assign mid_idx  = cur_hit ? cur_word.idx : take_idx;
    assign ovf_after = ovf_reg || (!cur_hit && cur_sat);

    assign resolving = (state_reg == ST_EDGE0) || (state_reg == ST_EDGE1) ||
                       (state_reg == ST_EDGE2);

    // ------------------------------------------------------------------
    // Datapath controls
    // ------------------------------------------------------------------
    always_comb begin
        rd_addr = pair_addr(rd_lo, rd_hi);
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_word = '{epoch: epoch_reg, idx: mid_idx};
        if (state_reg == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_word = '0;
        end else if (resolving && !cur_hit && cur_tab) begin
            wr_en = 1'b1;
        end
    end

    // Fold the current edge into the record
    always_comb begin
        rec_upd = rec_reg;
        case (state_reg)
            ST_EDGE0: begin
                rec_upd.mid_valid[0] = !cur_hit;
                rec_upd.mid_ovf[0]   = ovf_after;
                rec_upd.mid_lo[0]    = SLOT_W'(cur_lo);
                rec_upd.mid_hi[0]    = SLOT_W'(cur_hi);
                rec_upd.mid_idx[0]   = SLOT_W'(mid_idx);
                rec_upd.m_ab         = SLOT_W'(mid_idx);
            end
            ST_EDGE1: begin
                rec_upd.mid_valid[1] = !cur_hit;
                rec_upd.mid_ovf[1]   = ovf_after;
                rec_upd.mid_lo[1]    = SLOT_W'(cur_lo);
                rec_upd.mid_hi[1]    = SLOT_W'(cur_hi);
                rec_upd.mid_idx[1]   = SLOT_W'(mid_idx);
                rec_upd.m_bc         = SLOT_W'(mid_idx);
            end
            ST_EDGE2: begin
                rec_upd.mid_valid[2] = !cur_hit;
                rec_upd.mid_ovf[2]   = ovf_after;
                rec_upd.mid_lo[2]    = SLOT_W'(cur_lo);
                rec_upd.mid_hi[2]    = SLOT_W'(cur_hi);
                rec_upd.mid_idx[2]   = SLOT_W'(mid_idx);
                rec_upd.m_ca         = SLOT_W'(mid_idx);
                rec_upd.ovf          = ovf_after;
            end
            default: begin
                rec_upd.mid_valid = '0;
                rec_upd.crn_a     = SLOT_W'(a_reg);
                rec_upd.crn_b     = SLOT_W'(b_reg);
                rec_upd.crn_c     = SLOT_W'(c_reg);
            end
        endcase
        rec_next = rec_upd;
    end

    // Counter, flag and epoch; a first triangle overrides the finishing one
    always_comb begin
        nv_next      = nv_reg;
        ovf_next     = ovf_reg;
        epoch_next   = epoch_reg;
        clr_cnt_next = clr_cnt_reg;
        if (state_reg == ST_CLEAR) begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
        end
        if (resolving && !cur_hit) begin
            ovf_next = ovf_after;
            nv_next  = cur_sat ? NV_W'(MAX_VERTICES) : nv_reg + NV_W'(1);
        end
        if (s_fire && in_first) begin
            nv_next      = NV_W'(base_reg);
            ovf_next     = 1'b0;
            epoch_next   = (epoch_reg == EPOCH_LAST) ? EPOCH_FIRST : epoch_reg + EPOCH_W'(1);
            clr_cnt_next = '0;
        end
    end

    // Hand-off and output sequencing
    always_comb begin
        hand_valid_next = hand_valid_reg;
        emit_valid_next = emit_valid_reg;
        slot_next       = slot_reg;
        if (emit_load) begin
            hand_valid_next = 1'b0;
        end
        if (state_reg == ST_EDGE2) begin
            hand_valid_next = 1'b1;
        end
        if (emit_load) begin
            emit_valid_next = 1'b1;
            slot_next       = first_slot(hand_reg.mid_valid, SLOT_MID_AB);
        end else if (emit_done) begin
            emit_valid_next = 1'b0;
        end else if (m_fire) begin
            if (slot_reg < SLOT_TRI_A) begin
                slot_next = first_slot(emit_reg.mid_valid, slot_reg + 3'd1);
            end else begin
                slot_next = slot_reg + 3'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output beat from the held record
    // ------------------------------------------------------------------
    logic [SLOT_W-1:0] out_one, out_two, out_three;
    logic              out_ovf;

    always_comb begin
        m_tuser   = KIND_TRIANGLE;
        m_tlast   = 1'b0;
        out_ovf   = emit_reg.ovf;
        out_one   = emit_reg.m_ab;
        out_two   = emit_reg.m_bc;
        out_three = emit_reg.m_ca;
        case (slot_reg)
            SLOT_MID_AB, SLOT_MID_BC, SLOT_MID_CA: begin
                m_tuser   = KIND_MIDPOINT;
                out_ovf   = emit_reg.mid_ovf[slot_reg[1:0]];
                out_one   = emit_reg.mid_lo[slot_reg[1:0]];
                out_two   = emit_reg.mid_hi[slot_reg[1:0]];
                out_three = emit_reg.mid_idx[slot_reg[1:0]];
            end
            SLOT_TRI_A: begin
                out_one   = emit_reg.crn_a;
                out_two   = emit_reg.m_ab;
                out_three = emit_reg.m_ca;
            end
            SLOT_TRI_B: begin
                out_one   = emit_reg.m_ab;
                out_two   = emit_reg.crn_b;
                out_three = emit_reg.m_bc;
            end
            SLOT_TRI_C: begin
                out_one   = emit_reg.m_ca;
                out_two   = emit_reg.m_bc;
                out_three = emit_reg.crn_c;
            end
            SLOT_TRI_M: begin
                m_tlast = 1'b1;
            end
            default: begin
                m_tlast = 1'b0;
            end
        endcase
    end

    assign m_tvalid = emit_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_ovf, out_three, out_two, out_one});

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            epoch_reg      <= EPOCH_FIRST;
            nv_reg         <= '0;
            ovf_reg        <= 1'b0;
            base_reg       <= '0;
            hand_valid_reg <= 1'b0;
            emit_valid_reg <= 1'b0;
            slot_reg       <= SLOT_MID_AB;
            fwd_valid_reg  <= 1'b0;
            busy_item_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            epoch_reg      <= epoch_next;
            nv_reg         <= nv_next;
            ovf_reg        <= ovf_next;
            hand_valid_reg <= hand_valid_next;
            emit_valid_reg <= emit_valid_next;
            slot_reg       <= slot_next;
            fwd_valid_reg  <= wr_en;
            busy_item_reg  <= busy_item_next;
            if (cfg_valid && cfg_ready) begin
                base_reg <= cfg_data;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        rd_addr_reg  <= rd_addr;
        fwd_addr_reg <= wr_addr;
        fwd_word_reg <= wr_word;
        rec_reg      <= rec_next;
        if (s_fire) begin
            a_reg <= in_a;
            b_reg <= in_b;
            c_reg <= in_c;
        end
        if (state_reg == ST_EDGE2) begin
            hand_reg <= rec_upd;
        end
        if (emit_load) begin
            emit_reg <= hand_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hand_empty_at_last_edge: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EDGE2) |-> !hand_valid_reg)
        else $error("hand-off register overwritten");

    a_no_write_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("edge table written while idle");

    a_last_is_triangle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser == KIND_TRIANGLE))
        else $error("last beat is not a triangle");

    a_accept_starts_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg != ST_IDLE))
        else $error("accepted triangle dropped");

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input taken during clearing pass");

endmodule
